[rtl/snfa_pkg.sv]
// Shared types, constants and helper functions of the spring network force accumulator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package snfa_pkg;

  localparam int NodeCount = 64;
  localparam int AddrW     = $clog2(NodeCount);
  localparam int NodeW     = 6;
  localparam int CoordW    = 32;
  localparam int KW        = 32;
  localparam int ForceW    = 48;
  localparam int StatW     = 2;
  localparam int CmdW      = 2;
  localparam int MagW      = 34;
  localparam int SqW       = 2 * MagW;
  localparam int SqInW     = 70;
  localparam int RootW     = 35;
  localparam int KProdW    = KW + RootW;
  localparam int TenW      = 47;
  localparam int TenLoW    = 24;
  localparam int NumW      = TenW + MagW;
  localparam int RoundSh   = 20;

  localparam logic [CmdW-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CmdW-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CmdW-1:0] CMD_SPRING = 2'd2;
  localparam logic [CmdW-1:0] CMD_READ   = 2'd3;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [StatW-1:0] ST_SAT      = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_WRITE,
    OP_CLEAR,
    OP_SPRING,
    OP_READ
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_VEC,
    S_SQUARE,
    S_SUM,
    S_ROOT,
    S_TENSION,
    S_ROUND,
    S_PROD,
    S_PSUM,
    S_DIV,
    S_WR_A,
    S_WR_B,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic [AddrW-1:0]         a;
    logic [AddrW-1:0]         b;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] disp_x;
    logic signed [CoordW-1:0] disp_y;
    logic [KW-1:0]            k;
  } item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [CoordW-1:0] ux;
    logic signed [CoordW-1:0] uy;
  } geo_t;

  typedef struct packed {
    logic signed [ForceW-1:0] fx;
    logic signed [ForceW-1:0] fy;
  } frc_t;

  typedef struct packed {
    logic signed [ForceW-1:0] val;
    logic                     hit;
  } sat_t;

  function automatic logic [AddrW-1:0] to_addr(input logic [NodeW-1:0] n);
    logic [11:0] w;
    w = {6'b0, n};
    return w[AddrW-1:0];
  endfunction

  function automatic logic in_range(input logic [NodeW-1:0] n);
    return {7'b0, n} < 13'(NodeCount);
  endfunction

  function automatic logic [MagW-1:0] mag(input logic signed [MagW-1:0] v);
    logic signed [MagW-1:0] n;
    n = -v;
    return v[MagW-1] ? n : v;
  endfunction

  function automatic sat_t sat48(input logic signed [ForceW:0] v);
    sat_t r;
    if (v[ForceW] != v[ForceW-1]) begin
      r.hit = 1'b1;
      r.val = v[ForceW] ? {1'b1, {(ForceW-1){1'b0}}} : {1'b0, {(ForceW-1){1'b1}}};
    end else begin
      r.hit = 1'b0;
      r.val = v[ForceW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/spring_network_force_accumulator_top.sv]
// Top level of the spring network force accumulator: front end, queue and back end.
// Depends on snfa_pkg, snfa_front and snfa_back.
//
// Each beat takes one command and returns one result beat. Write node, clear all and
// out-of-range commands go straight to the result, a force read skips the arithmetic, and an
// apply-spring command runs it: the two lengths come from two digit-serial square root
// units of 35 steps each, the force components from two shift-subtract dividers of 47
// steps each. Clear all is done at once through per-node valid bits on the force table.
// A two-beat queue sits between input and the sequencer, and the result is held in an
// output register, so input beats are taken while a result waits.
`timescale 1ns / 1ps

module spring_network_force_accumulator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [snfa_pkg::CmdW-1:0]         cmd_i,
  input  logic [snfa_pkg::NodeW-1:0]        node_a_i,
  input  logic [snfa_pkg::NodeW-1:0]        node_b_i,
  input  logic signed [snfa_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [snfa_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [snfa_pkg::CoordW-1:0] disp_x_i,
  input  logic signed [snfa_pkg::CoordW-1:0] disp_y_i,
  input  logic [snfa_pkg::KW-1:0]           stiffness_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [snfa_pkg::ForceW-1:0] out_force_x_o,
  output logic signed [snfa_pkg::ForceW-1:0] out_force_y_o,
  output logic signed [snfa_pkg::ForceW-1:0] tension_o,
  output logic [snfa_pkg::StatW-1:0]        status_o
);

  logic            q_valid;
  logic            q_ready;
  snfa_pkg::item_t q_item;

  snfa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .node_a_i   (node_a_i),
    .node_b_i   (node_b_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .disp_x_i   (disp_x_i),
    .disp_y_i   (disp_y_i),
    .stiffness_i(stiffness_i),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  snfa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_ready_o    (q_ready),
    .q_item_i     (q_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_force_x_o(out_force_x_o),
    .out_force_y_o(out_force_y_o),
    .tension_o    (tension_o),
    .status_o     (status_o)
  );

endmodule

[rtl/snfa_front.sv]
// Front end: accepts input beats, classifies the command and checks node indexes.
// Holds classified items in a two-entry queue for the back end; uses snfa_pkg.
`timescale 1ns / 1ps

module snfa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [snfa_pkg::CmdW-1:0]        cmd_i,
  input  logic [snfa_pkg::NodeW-1:0]       node_a_i,
  input  logic [snfa_pkg::NodeW-1:0]       node_b_i,
  input  logic signed [snfa_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [snfa_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [snfa_pkg::CoordW-1:0] disp_x_i,
  input  logic signed [snfa_pkg::CoordW-1:0] disp_y_i,
  input  logic [snfa_pkg::KW-1:0]          stiffness_i,
  output logic                             q_valid_o,
  input  logic                             q_ready_i,
  output snfa_pkg::item_t                  q_item_o
);

  snfa_pkg::item_t item_c;
  snfa_pkg::item_t fifo_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push, pop;

  always_comb begin
    item_c.a      = snfa_pkg::to_addr(node_a_i);
    item_c.b      = snfa_pkg::to_addr(node_b_i);
    item_c.pos_x  = pos_x_i;
    item_c.pos_y  = pos_y_i;
    item_c.disp_x = disp_x_i;
    item_c.disp_y = disp_y_i;
    item_c.k      = stiffness_i;
    unique case (cmd_i)
      snfa_pkg::CMD_WRITE: begin
        item_c.op = snfa_pkg::in_range(node_a_i) ? snfa_pkg::OP_WRITE : snfa_pkg::OP_NOP;
      end
      snfa_pkg::CMD_CLEAR: begin
        item_c.op = snfa_pkg::OP_CLEAR;
      end
      snfa_pkg::CMD_SPRING: begin
        item_c.op = (snfa_pkg::in_range(node_a_i) && snfa_pkg::in_range(node_b_i))
                    ? snfa_pkg::OP_SPRING : snfa_pkg::OP_NOP;
      end
      default: begin
        item_c.op = snfa_pkg::in_range(node_a_i) ? snfa_pkg::OP_READ : snfa_pkg::OP_NOP;
      end
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = fifo_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= item_c;
    end
  end

endmodule

[rtl/snfa_sqrt.sv]
// Digit-serial integer square root, one result bit per cycle.
// Uses snfa_pkg for widths; instantiated by snfa_back.
`timescale 1ns / 1ps

module snfa_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [snfa_pkg::SqInW-1:0]    radicand_i,
  output logic                          busy_o,
  output logic [snfa_pkg::RootW-1:0]    root_o
);

  localparam int RemW = snfa_pkg::RootW + 2;
  localparam int CntW = $clog2(snfa_pkg::RootW);

  logic [snfa_pkg::SqInW-1:0] rad_q;
  logic [RemW-1:0]            rem_q;
  logic [snfa_pkg::RootW-1:0] root_q;
  logic [CntW-1:0]            cnt_q;
  logic                       busy_q;
  logic [RemW+1:0]            shifted;
  logic [RemW+1:0]            trial;
  logic                       ge;
  logic [RemW+1:0]            diff;

  always_comb begin
    shifted = {rem_q, rad_q[snfa_pkg::SqInW-1 -: 2]};
    trial   = (RemW+2)'({root_q, 2'b01});
    ge      = shifted >= trial;
    diff    = shifted - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(snfa_pkg::RootW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[snfa_pkg::SqInW-3:0], 2'b00};
      rem_q  <= ge ? diff[RemW-1:0] : shifted[RemW-1:0];
      root_q <= {root_q[snfa_pkg::RootW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

[rtl/snfa_div.sv]
// Shift-subtract divider, one quotient bit per cycle, for a quotient known to fit TenW bits.
// Uses snfa_pkg for widths; instantiated by snfa_back.
`timescale 1ns / 1ps

module snfa_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [snfa_pkg::NumW-1:0]    num_i,
  input  logic [snfa_pkg::RootW-1:0]   den_i,
  output logic                         busy_o,
  output logic [snfa_pkg::TenW-1:0]    quot_o
);

  localparam int CntW = $clog2(snfa_pkg::TenW);

  logic [snfa_pkg::RootW-1:0] rem_q;
  logic [snfa_pkg::RootW-1:0] den_q;
  logic [snfa_pkg::TenW-1:0]  lo_q;
  logic [CntW-1:0]            cnt_q;
  logic                       busy_q;
  logic [snfa_pkg::RootW:0]   sh;
  logic                       ge;
  logic [snfa_pkg::RootW:0]   diff;

  always_comb begin
    sh   = {rem_q, lo_q[snfa_pkg::TenW-1]};
    ge   = sh >= {1'b0, den_q};
    diff = sh - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntW'(snfa_pkg::TenW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= snfa_pkg::RootW'(num_i[snfa_pkg::NumW-1:snfa_pkg::TenW]);
      lo_q  <= num_i[snfa_pkg::TenW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[snfa_pkg::RootW-1:0] : sh[snfa_pkg::RootW-1:0];
      lo_q  <= {lo_q[snfa_pkg::TenW-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = lo_q;

endmodule

[rtl/snfa_back.sv]
// Back end: node tables, spring force sequencer and the output register.
// Uses snfa_pkg, two snfa_sqrt units and two snfa_div units.
`timescale 1ns / 1ps

module snfa_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  snfa_pkg::item_t                   q_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [snfa_pkg::ForceW-1:0] out_force_x_o,
  output logic signed [snfa_pkg::ForceW-1:0] out_force_y_o,
  output logic signed [snfa_pkg::ForceW-1:0] tension_o,
  output logic [snfa_pkg::StatW-1:0]        status_o
);

  localparam int FW = snfa_pkg::ForceW;
  localparam int MW = snfa_pkg::MagW;

  snfa_pkg::state_e state_q, state_d;
  snfa_pkg::item_t  item_q;
  logic             pop, sq_start, dv_start, out_load;

  snfa_pkg::geo_t geo_mem [snfa_pkg::NodeCount];
  snfa_pkg::frc_t frc_mem [snfa_pkg::NodeCount];
  logic [snfa_pkg::NodeCount-1:0] fvalid_q;

  snfa_pkg::geo_t geo_a_q, geo_b_q;
  snfa_pkg::frc_t frc_a_q, frc_b_q;
  logic           fv_a_q, fv_b_q;
  snfa_pkg::frc_t acc_a, acc_b, new_a, new_b;
  snfa_pkg::sat_t sat_ax, sat_ay, sat_bx, sat_by;

  logic signed [MW-1:0]             dx_q, dy_q, rx_q, ry_q;
  logic [MW-1:0]                    mdx, mdy;
  logic [snfa_pkg::SqW-1:0]         sdx_q, sdy_q, srx_q, sry_q;
  logic [snfa_pkg::SqInW-1:0]       sum_d, sum_r;
  logic                             busy_d, busy_r, busy_x, busy_y;
  logic [snfa_pkg::RootW-1:0]       len, len0, emag;
  logic                             eneg_q;
  logic [snfa_pkg::KProdW-1:0]      kprod_q;
  logic [snfa_pkg::KProdW:0]        rnd;
  logic [snfa_pkg::TenW-1:0]        tmag_q;
  logic signed [FW-1:0]             ten_q;
  logic [snfa_pkg::TenLoW+MW-1:0]   pxl_q, pyl_q;
  logic [snfa_pkg::TenW-snfa_pkg::TenLoW+MW-1:0] pxh_q, pyh_q;
  logic [snfa_pkg::NumW-1:0]        num_x, num_y;
  logic [snfa_pkg::TenW-1:0]        qx, qy;
  logic signed [FW-1:0]             fx_q, fy_q, qxs, qys;
  logic [snfa_pkg::StatW-1:0]       st_q;

  logic                             out_valid_q;
  logic signed [FW-1:0]             ofx_q, ofy_q, oten_q;
  logic [snfa_pkg::StatW-1:0]       ost_q;

  assign q_ready_o = (state_q == snfa_pkg::S_IDLE);
  assign pop       = q_valid_i && q_ready_o;

  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      snfa_pkg::S_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.op == snfa_pkg::OP_READ || q_item_i.op == snfa_pkg::OP_SPRING) begin
            state_d = snfa_pkg::S_READ;
          end else begin
            state_d = snfa_pkg::S_DONE;
          end
        end
      end
      snfa_pkg::S_READ: begin
        state_d = (item_q.op == snfa_pkg::OP_SPRING) ? snfa_pkg::S_VEC : snfa_pkg::S_DONE;
      end
      snfa_pkg::S_VEC:    state_d = snfa_pkg::S_SQUARE;
      snfa_pkg::S_SQUARE: state_d = snfa_pkg::S_SUM;
      snfa_pkg::S_SUM: begin
        sq_start = 1'b1;
        state_d  = snfa_pkg::S_ROOT;
      end
      snfa_pkg::S_ROOT: begin
        if (!busy_d && !busy_r) begin
          state_d = snfa_pkg::S_TENSION;
        end
      end
      snfa_pkg::S_TENSION: state_d = snfa_pkg::S_ROUND;
      snfa_pkg::S_ROUND: begin
        state_d = (len == '0) ? snfa_pkg::S_DONE : snfa_pkg::S_PROD;
      end
      snfa_pkg::S_PROD: state_d = snfa_pkg::S_PSUM;
      snfa_pkg::S_PSUM: begin
        dv_start = 1'b1;
        state_d  = snfa_pkg::S_DIV;
      end
      snfa_pkg::S_DIV: begin
        if (!busy_x && !busy_y) begin
          state_d = snfa_pkg::S_WR_A;
        end
      end
      snfa_pkg::S_WR_A: state_d = snfa_pkg::S_WR_B;
      snfa_pkg::S_WR_B: state_d = snfa_pkg::S_DONE;
      snfa_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = snfa_pkg::S_IDLE;
        end
      end
      default: state_d = snfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= snfa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Node tables. The force table reads as zero wherever its valid bit is clear.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      geo_a_q <= geo_mem[q_item_i.a];
      geo_b_q <= geo_mem[q_item_i.b];
      frc_a_q <= frc_mem[q_item_i.a];
      frc_b_q <= frc_mem[q_item_i.b];
    end
    if (pop && q_item_i.op == snfa_pkg::OP_WRITE) begin
      geo_mem[q_item_i.a] <= {q_item_i.pos_x, q_item_i.pos_y, q_item_i.disp_x, q_item_i.disp_y};
    end
    if (state_q == snfa_pkg::S_WR_A) begin
      frc_mem[item_q.a] <= new_a;
    end else if (state_q == snfa_pkg::S_WR_B) begin
      frc_mem[item_q.b] <= new_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= '0;
      fv_a_q   <= 1'b0;
      fv_b_q   <= 1'b0;
    end else begin
      if (pop) begin
        fv_a_q <= fvalid_q[q_item_i.a];
        fv_b_q <= fvalid_q[q_item_i.b];
      end
      if (pop && q_item_i.op == snfa_pkg::OP_CLEAR) begin
        fvalid_q <= '0;
      end else if (pop && q_item_i.op == snfa_pkg::OP_WRITE) begin
        fvalid_q[q_item_i.a] <= 1'b0;
      end else if (state_q == snfa_pkg::S_WR_A) begin
        fvalid_q[item_q.a] <= 1'b1;
      end else if (state_q == snfa_pkg::S_WR_B) begin
        fvalid_q[item_q.b] <= 1'b1;
      end
    end
  end

  always_comb begin
    acc_a  = fv_a_q ? frc_a_q : '0;
    acc_b  = fv_b_q ? frc_b_q : '0;
    sat_ax = snfa_pkg::sat48((FW+1)'(acc_a.fx) + (FW+1)'(fx_q));
    sat_ay = snfa_pkg::sat48((FW+1)'(acc_a.fy) + (FW+1)'(fy_q));
    sat_bx = snfa_pkg::sat48((FW+1)'(acc_b.fx) - (FW+1)'(fx_q));
    sat_by = snfa_pkg::sat48((FW+1)'(acc_b.fy) - (FW+1)'(fy_q));
    new_a  = {sat_ax.val, sat_ay.val};
    new_b  = {sat_bx.val, sat_by.val};
  end

  always_comb begin
    mdx   = snfa_pkg::mag(dx_q);
    mdy   = snfa_pkg::mag(dy_q);
    sum_d = snfa_pkg::SqInW'(sdx_q) + snfa_pkg::SqInW'(sdy_q);
    sum_r = snfa_pkg::SqInW'(srx_q) + snfa_pkg::SqInW'(sry_q);
    emag  = (len < len0) ? (len0 - len) : (len - len0);
    rnd   = (snfa_pkg::KProdW+1)'(kprod_q) + (snfa_pkg::KProdW+1)'(2 ** (snfa_pkg::RoundSh - 1));
    num_x = snfa_pkg::NumW'(pxl_q) + (snfa_pkg::NumW'(pxh_q) << snfa_pkg::TenLoW);
    num_y = snfa_pkg::NumW'(pyl_q) + (snfa_pkg::NumW'(pyh_q) << snfa_pkg::TenLoW);
    qxs   = FW'(qx);
    qys   = FW'(qy);
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      item_q <= q_item_i;
    end
    unique case (state_q)
      snfa_pkg::S_VEC: begin
        dx_q <= MW'(geo_b_q.px) + MW'(geo_b_q.ux) - MW'(geo_a_q.px) - MW'(geo_a_q.ux);
        dy_q <= MW'(geo_b_q.py) + MW'(geo_b_q.uy) - MW'(geo_a_q.py) - MW'(geo_a_q.uy);
        rx_q <= MW'(geo_b_q.px) - MW'(geo_a_q.px);
        ry_q <= MW'(geo_b_q.py) - MW'(geo_a_q.py);
      end
      snfa_pkg::S_SQUARE: begin
        sdx_q <= mdx * mdx;
        sdy_q <= mdy * mdy;
        srx_q <= snfa_pkg::mag(rx_q) * snfa_pkg::mag(rx_q);
        sry_q <= snfa_pkg::mag(ry_q) * snfa_pkg::mag(ry_q);
      end
      snfa_pkg::S_TENSION: begin
        eneg_q  <= len < len0;
        kprod_q <= item_q.k * emag;
      end
      snfa_pkg::S_ROUND: begin
        tmag_q <= rnd[snfa_pkg::RoundSh +: snfa_pkg::TenW];
        ten_q  <= eneg_q ? -FW'(rnd[snfa_pkg::RoundSh +: snfa_pkg::TenW])
                         : FW'(rnd[snfa_pkg::RoundSh +: snfa_pkg::TenW]);
        fx_q   <= '0;
        fy_q   <= '0;
      end
      snfa_pkg::S_PROD: begin
        pxl_q <= tmag_q[snfa_pkg::TenLoW-1:0] * mdx;
        pyl_q <= tmag_q[snfa_pkg::TenLoW-1:0] * mdy;
        pxh_q <= tmag_q[snfa_pkg::TenW-1:snfa_pkg::TenLoW] * mdx;
        pyh_q <= tmag_q[snfa_pkg::TenW-1:snfa_pkg::TenLoW] * mdy;
      end
      snfa_pkg::S_DIV: begin
        fx_q <= (eneg_q ^ dx_q[MW-1]) ? -qxs : qxs;
        fy_q <= (eneg_q ^ dy_q[MW-1]) ? -qys : qys;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= snfa_pkg::ST_OK;
    end else if (pop) begin
      st_q <= snfa_pkg::ST_OK;
    end else if (state_q == snfa_pkg::S_ROUND && len == '0) begin
      st_q <= snfa_pkg::ST_ZERO_LEN;
    end else if (state_q == snfa_pkg::S_WR_A && (sat_ax.hit || sat_ay.hit)) begin
      st_q <= snfa_pkg::ST_SAT;
    end else if (state_q == snfa_pkg::S_WR_B && (sat_bx.hit || sat_by.hit)) begin
      st_q <= snfa_pkg::ST_SAT;
    end
  end

  snfa_sqrt u_sqrt_d (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .radicand_i(sum_d),
    .busy_o    (busy_d),
    .root_o    (len)
  );

  snfa_sqrt u_sqrt_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sq_start),
    .radicand_i(sum_r),
    .busy_o    (busy_r),
    .root_o    (len0)
  );

  snfa_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (num_x),
    .den_i  (len),
    .busy_o (busy_x),
    .quot_o (qx)
  );

  snfa_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dv_start),
    .num_i  (num_y),
    .den_i  (len),
    .busy_o (busy_y),
    .quot_o (qy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      case (item_q.op)
        snfa_pkg::OP_READ: begin
          ofx_q  <= acc_a.fx;
          ofy_q  <= acc_a.fy;
          oten_q <= '0;
          ost_q  <= snfa_pkg::ST_OK;
        end
        snfa_pkg::OP_SPRING: begin
          ofx_q  <= fx_q;
          ofy_q  <= fy_q;
          oten_q <= ten_q;
          ost_q  <= st_q;
        end
        default: begin
          ofx_q  <= '0;
          ofy_q  <= '0;
          oten_q <= '0;
          ost_q  <= snfa_pkg::ST_OK;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_force_x_o = ofx_q;
  assign out_force_y_o = ofy_q;
  assign tension_o     = oten_q;
  assign status_o      = ost_q;

  a_wr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == snfa_pkg::S_WR_A |=> state_q == snfa_pkg::S_WR_B)
    else $error("Node b update did not follow node a update.");

  a_zero_len_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == snfa_pkg::ST_ZERO_LEN |-> out_force_x_o == '0 &&
    out_force_y_o == '0)
    else $error("Zero deformed length reported a nonzero force.");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> !busy_d && !busy_r && !busy_x && !busy_y)
    else $error("Arithmetic unit busy while the sequencer is idle.");

endmodule
